[rtl/lfl_pkg.sv]
// Shared types, constants and helper functions of the logic formula tokenizer.
// No dependencies; every other file of the block imports this package.
package lfl_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int LENGTH_BITS = 16;
  localparam int LINE_BITS   = 24;
  localparam int COL_BITS    = 16;
  localparam int KIND_BITS   = 6;
  localparam int ERR_BITS    = 3;
  localparam int BURST_MAX   = 3;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [COL_BITS-1:0]    COL_MAX  = {COL_BITS{1'b1}};

  localparam logic [KIND_BITS-1:0] K_TILDE_AMP = 6'd10;
  localparam logic [KIND_BITS-1:0] K_TILDE_BAR = 6'd11;
  localparam logic [KIND_BITS-1:0] K_TILDE     = 6'd12;
  localparam logic [KIND_BITS-1:0] K_NEQ       = 6'd13;
  localparam logic [KIND_BITS-1:0] K_BANG      = 6'd14;
  localparam logic [KIND_BITS-1:0] K_IMPL      = 6'd15;
  localparam logic [KIND_BITS-1:0] K_EQ        = 6'd16;
  localparam logic [KIND_BITS-1:0] K_EQUIV     = 6'd17;
  localparam logic [KIND_BITS-1:0] K_LE        = 6'd18;
  localparam logic [KIND_BITS-1:0] K_XOR       = 6'd19;
  localparam logic [KIND_BITS-1:0] K_DOT       = 6'd5;
  localparam logic [KIND_BITS-1:0] K_NAME      = 6'd20;
  localparam logic [KIND_BITS-1:0] K_DISTINCT  = 6'd21;
  localparam logic [KIND_BITS-1:0] K_DOLLAR    = 6'd22;
  localparam logic [KIND_BITS-1:0] K_INT       = 6'd23;
  localparam logic [KIND_BITS-1:0] K_REAL      = 6'd24;
  localparam logic [KIND_BITS-1:0] K_VAR       = 6'd25;
  localparam logic [KIND_BITS-1:0] K_KW        = 6'd26;
  localparam logic [KIND_BITS-1:0] K_ERROR     = 6'd31;
  localparam logic [KIND_BITS-1:0] K_END       = 6'd32;

  localparam logic [ERR_BITS-1:0] E_NONE     = 3'd0;
  localparam logic [ERR_BITS-1:0] E_UNEXP    = 3'd1;
  localparam logic [ERR_BITS-1:0] E_LT       = 3'd2;
  localparam logic [ERR_BITS-1:0] E_UNTERM   = 3'd3;
  localparam logic [ERR_BITS-1:0] E_EXPONENT = 3'd4;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam int KW_NUM = 5;
  localparam logic [0:KW_NUM-1][0:6][7:0] KW_TEXT = '{
    '{"f", "o", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "n", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "h", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "f", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", "c", "l", "u", "d", "e"}
  };
  localparam logic [0:KW_NUM-1][2:0] KW_LEN = '{3'd3, 3'd3, 3'd3, 3'd3, 3'd7};

  typedef enum logic [4:0] {
    M_IDLE, M_COMMENT, M_SLASH, M_BLOCK, M_BLOCK_STAR, M_TILDE, M_BANG,
    M_EQ, M_LT, M_LT_EQ, M_LT_TILDE, M_SIGN, M_NUM_INT, M_NUM_DOT,
    M_NUM_FRAC, M_NUM_E, M_NUM_ESIGN, M_NUM_EXP, M_IDENT, M_DOLLAR,
    M_SQ, M_SQ_BS, M_DQ, M_DQ_BS
  } scan_mode_e;

  typedef struct packed {
    logic       command;
    logic [7:0] char_byte;
  } in_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]   token_kind;
    logic [ERR_BITS-1:0]    error_code;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [LENGTH_BITS-1:0] token_length;
    logic [LINE_BITS-1:0]   line_number;
    logic [COL_BITS-1:0]    column_number;
    logic                   last_of_run;
  } out_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [ERR_BITS-1:0]    err;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [COL_BITS-1:0]    col;
  } tok_t;

  // All tokens caused by one input item, oldest in slot 0.
  typedef struct packed {
    tok_t [BURST_MAX-1:0] tok;
    logic [1:0]           cnt;
  } burst_t;

  function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
    return (v < LEN_MAX) ? v + 1'b1 : v;
  endfunction

  // Keywords still matching after character c at position idx.
  function automatic logic [KW_NUM-1:0] kw_keep(input logic [LENGTH_BITS-1:0] idx,
                                                input logic [7:0] c);
    logic [KW_NUM-1:0] m;
    m = '0;
    for (int k = 0; k < KW_NUM; k++) begin
      if (idx < LENGTH_BITS'(KW_LEN[k])) begin
        m[k] = (KW_TEXT[k][idx[2:0]] == c);
      end
    end
    return m;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return is_upper(c) || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

endpackage

[rtl/lfl_front.sv]
// Scanner front end: accepts one byte or end command per transfer, advances the
// scan state and builds the burst of tokens it completes. Uses lfl_pkg.
module lfl_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  lfl_pkg::in_t  item_i,
  output lfl_pkg::burst_t burst_o
);
  import lfl_pkg::*;

  scan_mode_e             mode_q, mode_d;
  logic [OFFSET_BITS-1:0] tstart_q, tstart_d, off_q, off_d, hoff_q, hoff_d;
  logic [LENGTH_BITS-1:0] tlen_q, tlen_d;
  logic [COL_BITS-1:0]    tcol_q, tcol_d, hcol_q, hcol_d, col_q, col_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic                   hvalid_q, hvalid_d, upper_q, upper_d, sfe_q, sfe_d;
  logic [KW_NUM-1:0]      hits_q, hits_d;

  tok_t [BURST_MAX-1:0]   em;
  logic [1:0]             n;

  function automatic tok_t mk(input logic [KIND_BITS-1:0] kind,
                              input logic [ERR_BITS-1:0] err,
                              input logic [OFFSET_BITS-1:0] start,
                              input logic [LENGTH_BITS-1:0] len,
                              input logic [COL_BITS-1:0] col,
                              input logic [LINE_BITS-1:0] line);
    tok_t t;
    t.kind  = kind;
    t.err   = err;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.col   = col;
    return t;
  endfunction

  always_comb begin
    logic [7:0]           c;
    logic                 fin, beg;
    logic [KIND_BITS-1:0] kk;
    c        = item_i.char_byte;
    fin      = 1'b0;
    beg      = 1'b0;
    kk       = K_NAME;
    mode_d   = mode_q;
    tstart_d = tstart_q;
    tlen_d   = tlen_q;
    tcol_d   = tcol_q;
    hoff_d   = hoff_q;
    hcol_d   = hcol_q;
    hvalid_d = hvalid_q;
    hits_d   = hits_q;
    upper_d  = upper_q;
    sfe_d    = sfe_q;
    off_d    = off_q;
    line_d   = line_q;
    col_d    = col_q;
    em       = '0;
    n        = '0;

    if (item_i.command == CMD_END) begin
      fin = 1'b1;
    end else begin
      case (mode_q)
        M_IDLE:    beg = 1'b1;
        M_COMMENT: if (c == 8'h0A) mode_d = M_IDLE;
        M_SLASH: begin
          if (c == "*") mode_d = M_BLOCK;
          else fin = 1'b1;
        end
        M_BLOCK:   if (c == "*") mode_d = M_BLOCK_STAR;
        M_BLOCK_STAR: begin
          if (c == "/") mode_d = M_IDLE;
          else if (c != "*") mode_d = M_BLOCK;
        end
        M_TILDE: begin
          if (c == "&" || c == "|") begin
            tlen_d = len_inc(tlen_q);
            em[n] = mk((c == "&") ? K_TILDE_AMP : K_TILDE_BAR, E_NONE, tstart_q, tlen_d,
                       tcol_q, line_q);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end else fin = 1'b1;
        end
        M_BANG, M_EQ: begin
          if ((mode_q == M_BANG && c == "=") || (mode_q == M_EQ && c == ">")) begin
            tlen_d = len_inc(tlen_q);
            em[n] = mk((mode_q == M_BANG) ? K_NEQ : K_IMPL, E_NONE, tstart_q, tlen_d,
                       tcol_q, line_q);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end else fin = 1'b1;
        end
        M_LT: begin
          if (c == "=" || c == "~") begin
            tlen_d = len_inc(tlen_q);
            mode_d = (c == "=") ? M_LT_EQ : M_LT_TILDE;
          end else fin = 1'b1;
        end
        M_LT_EQ, M_LT_TILDE: begin
          if (c == ">") begin
            tlen_d = len_inc(tlen_q);
            em[n] = mk((mode_q == M_LT_EQ) ? K_EQUIV : K_XOR, E_NONE, tstart_q, tlen_d,
                       tcol_q, line_q);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end else fin = 1'b1;
        end
        M_SIGN: begin
          if (is_digit(c)) begin
            tlen_d = len_inc(tlen_q);
            mode_d = M_NUM_INT;
          end else fin = 1'b1;
        end
        M_NUM_INT, M_NUM_FRAC: begin
          if (is_digit(c)) tlen_d = len_inc(tlen_q);
          else if (c == "e" || c == "E") begin
            tlen_d = len_inc(tlen_q);
            sfe_d  = 1'b1;
            mode_d = M_NUM_E;
          end else if (c == "." && mode_q == M_NUM_INT) begin
            hvalid_d = 1'b1;
            hoff_d   = off_q;
            hcol_d   = col_q;
            mode_d   = M_NUM_DOT;
          end else fin = 1'b1;
        end
        M_NUM_DOT: begin
          if (is_digit(c)) begin
            tlen_d   = len_inc(len_inc(tlen_q));
            sfe_d    = 1'b1;
            hvalid_d = 1'b0;
            mode_d   = M_NUM_FRAC;
          end else fin = 1'b1;
        end
        M_NUM_E: begin
          if (c == "+" || c == "-") begin
            tlen_d = len_inc(tlen_q);
            mode_d = M_NUM_ESIGN;
          end else if (is_digit(c)) begin
            tlen_d = len_inc(tlen_q);
            mode_d = M_NUM_EXP;
          end else fin = 1'b1;
        end
        M_NUM_ESIGN, M_NUM_EXP: begin
          if (is_digit(c)) begin
            tlen_d = len_inc(tlen_q);
            mode_d = M_NUM_EXP;
          end else fin = 1'b1;
        end
        M_IDENT: begin
          if (is_word(c)) begin
            hits_d = hits_q & kw_keep(tlen_q, c);
            tlen_d = len_inc(tlen_q);
          end else fin = 1'b1;
        end
        M_DOLLAR: begin
          if (is_word(c)) tlen_d = len_inc(tlen_q);
          else fin = 1'b1;
        end
        M_SQ, M_DQ: begin
          tlen_d = len_inc(tlen_q);
          if ((mode_q == M_SQ && c == "'") || (mode_q == M_DQ && c == "\"")) begin
            em[n] = mk((mode_q == M_SQ) ? K_NAME : K_DISTINCT, E_NONE, tstart_q, tlen_d,
                       tcol_q, line_q);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end else if (c == "\\") begin
            mode_d = (mode_q == M_SQ) ? M_SQ_BS : M_DQ_BS;
          end
        end
        M_SQ_BS, M_DQ_BS: begin
          // escaped quote just counts; anything else is rescanned inside the string
          tlen_d = len_inc(tlen_q);
          if ((mode_q == M_SQ_BS && c == "'") || (mode_q == M_DQ_BS && c == "\"")) begin
            mode_d = (mode_q == M_SQ_BS) ? M_SQ : M_DQ;
          end else if (c == "\\") begin
            mode_d = mode_q;
          end else begin
            mode_d = (mode_q == M_SQ_BS) ? M_SQ : M_DQ;
          end
        end
        default: beg = 1'b1;
      endcase
    end

    if (fin) begin
      case (mode_q)
        M_SLASH, M_SIGN: begin
          em[n] = mk(K_ERROR, E_UNEXP, tstart_q, tlen_q, tcol_q, line_q);
          n = n + 2'd1;
        end
        M_TILDE, M_BANG, M_EQ, M_LT_EQ, M_DOLLAR: begin
          case (mode_q)
            M_TILDE: kk = K_TILDE;
            M_BANG:  kk = K_BANG;
            M_EQ:    kk = K_EQ;
            M_LT_EQ: kk = K_LE;
            default: kk = K_DOLLAR;
          endcase
          em[n] = mk(kk, E_NONE, tstart_q, tlen_q, tcol_q, line_q);
          n = n + 2'd1;
        end
        M_LT, M_LT_TILDE: begin
          em[n] = mk(K_ERROR, E_LT, tstart_q, tlen_q, tcol_q, line_q);
          n = n + 2'd1;
        end
        M_NUM_INT, M_NUM_FRAC, M_NUM_EXP, M_NUM_DOT: begin
          em[n] = mk(sfe_q ? K_REAL : K_INT, E_NONE, tstart_q, tlen_q, tcol_q, line_q);
          n = n + 2'd1;
          if (mode_q == M_NUM_DOT && hvalid_q) begin
            em[n] = mk(K_DOT, E_NONE, hoff_q, LENGTH_BITS'(1), hcol_q, line_q);
            n = n + 2'd1;
          end
        end
        M_NUM_E, M_NUM_ESIGN: begin
          em[n] = mk(K_ERROR, E_EXPONENT, tstart_q, tlen_q, tcol_q, line_q);
          n = n + 2'd1;
        end
        M_IDENT: begin
          kk = upper_q ? K_VAR : K_NAME;
          for (int k = KW_NUM - 1; k >= 0; k--) begin
            if (hits_q[k] && tlen_q == LENGTH_BITS'(KW_LEN[k])) kk = K_KW + KIND_BITS'(k);
          end
          em[n] = mk(kk, E_NONE, tstart_q, tlen_q, tcol_q, line_q);
          n = n + 2'd1;
        end
        M_SQ, M_SQ_BS, M_DQ, M_DQ_BS: begin
          em[n] = mk(K_ERROR, E_UNTERM, tstart_q, tlen_q, tcol_q, line_q);
          n = n + 2'd1;
        end
        default: ;
      endcase
      hvalid_d = 1'b0;
      mode_d   = M_IDLE;
      if (item_i.command == CMD_BYTE) beg = 1'b1;
    end

    if (beg) begin
      tstart_d = off_q;
      tcol_d   = col_q;
      tlen_d   = LENGTH_BITS'(1);
      mode_d   = M_IDLE;
      kk       = '0;
      case (c)
        "(", ")", "[", "]", ",", ".", ":", "&", "|", "?": begin
          case (c)
            "(":     kk = 6'd0;
            ")":     kk = 6'd1;
            "[":     kk = 6'd2;
            "]":     kk = 6'd3;
            ",":     kk = 6'd4;
            ".":     kk = K_DOT;
            ":":     kk = 6'd6;
            "&":     kk = 6'd7;
            "|":     kk = 6'd8;
            default: kk = 6'd9;
          endcase
          em[n] = mk(kk, E_NONE, off_q, LENGTH_BITS'(1), col_q, line_q);
          n = n + 2'd1;
        end
        " ", "\t", 8'h0D, 8'h0A: ;
        "%":  mode_d = M_COMMENT;
        "/":  mode_d = M_SLASH;
        "~":  mode_d = M_TILDE;
        "!":  mode_d = M_BANG;
        "=":  mode_d = M_EQ;
        "<":  mode_d = M_LT;
        "+", "-": begin
          mode_d = M_SIGN;
          sfe_d  = 1'b0;
        end
        "'":  mode_d = M_SQ;
        "\"": mode_d = M_DQ;
        "$":  mode_d = M_DOLLAR;
        default: begin
          if (is_digit(c)) begin
            mode_d = M_NUM_INT;
            sfe_d  = 1'b0;
          end else if (is_alpha(c) || c == "_") begin
            mode_d  = M_IDENT;
            hits_d  = kw_keep('0, c);
            upper_d = is_upper(c) || c == "_";
          end else begin
            em[n] = mk(K_ERROR, E_UNEXP, off_q, LENGTH_BITS'(1), col_q, line_q);
            n = n + 2'd1;
          end
        end
      endcase
    end

    if (item_i.command == CMD_END) begin
      em[n] = mk(K_END, E_NONE, off_q, '0, col_q, line_q);
      n = n + 2'd1;
      mode_d   = M_IDLE;
      tstart_d = '0;
      tlen_d   = '0;
      tcol_d   = COL_BITS'(1);
      hoff_d   = '0;
      hcol_d   = '0;
      hvalid_d = 1'b0;
      hits_d   = '1;
      upper_d  = 1'b0;
      sfe_d    = 1'b0;
      off_d    = '0;
      line_d   = LINE_BITS'(1);
      col_d    = COL_BITS'(1);
    end else begin
      off_d = off_q + 1'b1;
      if (c == 8'h0A) begin
        col_d = COL_BITS'(1);
        if (line_q < LINE_MAX) line_d = line_q + 1'b1;
      end else if (col_q < COL_MAX) begin
        col_d = col_q + 1'b1;
      end
    end
    burst_o.tok = em;
    burst_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      tstart_q <= '0;
      tlen_q   <= '0;
      tcol_q   <= COL_BITS'(1);
      hoff_q   <= '0;
      hcol_q   <= '0;
      hvalid_q <= 1'b0;
      hits_q   <= '1;
      upper_q  <= 1'b0;
      sfe_q    <= 1'b0;
      off_q    <= '0;
      line_q   <= LINE_BITS'(1);
      col_q    <= COL_BITS'(1);
    end else if (take_i) begin
      mode_q   <= mode_d;
      tstart_q <= tstart_d;
      tlen_q   <= tlen_d;
      tcol_q   <= tcol_d;
      hoff_q   <= hoff_d;
      hcol_q   <= hcol_d;
      hvalid_q <= hvalid_d;
      hits_q   <= hits_d;
      upper_q  <= upper_d;
      sfe_q    <= sfe_d;
      off_q    <= off_d;
      line_q   <= line_d;
      col_q    <= col_d;
    end
  end

endmodule

[rtl/lfl_fifo.sv]
// Short queue of token bursts between scanner front end and output stage.
// Uses lfl_pkg for the burst type and depth.
module lfl_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lfl_pkg::burst_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output lfl_pkg::burst_t data_o
);
  import lfl_pkg::*;

  burst_t                mem_q [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_q, rd_q;
  logic [Q_PTR_BITS:0]   cnt_q;

  assign full_o  = (cnt_q == (Q_PTR_BITS+1)'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (Q_PTR_BITS+1)'(push_i) - (Q_PTR_BITS+1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("burst queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("burst queue underflow");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Q_PTR_BITS+1)'(Q_DEPTH)) else $error("burst queue count out of range");
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> data_i.cnt != 2'd0) else $error("empty burst queued");

endmodule

[rtl/lfl_back.sv]
// Output stage: takes bursts from the queue and hands out their tokens one per
// transfer, marking the last token of each burst. Uses lfl_pkg.
module lfl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  lfl_pkg::burst_t burst_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lfl_pkg::out_t   out_data_o
);
  import lfl_pkg::*;

  burst_t     cur_q;
  logic       valid_q;
  logic [1:0] idx_q;
  logic       last;
  tok_t       t;

  assign last        = (idx_q == cur_q.cnt - 2'd1);
  assign t           = cur_q.tok[idx_q];
  assign out_valid_o = valid_q;
  assign pop_o       = !empty_i && (!valid_q || (out_ready_i && last));

  always_comb begin
    out_data_o.token_kind    = t.kind;
    out_data_o.error_code    = t.err;
    out_data_o.start_offset  = t.start;
    out_data_o.token_length  = t.len;
    out_data_o.line_number   = t.line;
    out_data_o.column_number = t.col;
    out_data_o.last_of_run   = last;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= burst_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && out_ready_i) begin
      if (last) valid_q <= 1'b0;
      else idx_q <= idx_q + 2'd1;
    end
  end

  a_idx_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> idx_q < cur_q.cnt) else $error("token index past burst end");
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(idx_q))
    else $error("stalled token dropped");
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_ready_i && !last |=> valid_q && idx_q == $past(idx_q) + 2'd1)
    else $error("burst token skipped");

endmodule

[rtl/logic_formula_tokenizer.sv]
// Streaming tokenizer for first-order formula text. One source byte or end
// command is taken per transfer, up to one per cycle while the queue is not
// full; the front end scans it in the cycle it is taken and queues the one to
// three tokens it completes, if any, as one burst in a four-entry queue. The
// output stage hands out one token per cycle while out_ready_i is high; items
// yielding at most one token thus sustain one per cycle, bursts go at its pace.
// Depends on lfl_pkg, lfl_front, lfl_fifo and lfl_back.
module logic_formula_tokenizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lfl_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lfl_pkg::out_t out_data_o
);
  import lfl_pkg::*;

  burst_t fr_burst, q_burst;
  logic   take, q_full, q_empty, q_pop;

  assign in_ready_o = !q_full;
  assign take       = in_valid_i && in_ready_o;

  lfl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .item_i  (in_data_i),
    .burst_o (fr_burst)
  );

  lfl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take && fr_burst.cnt != 2'd0),
    .data_i  (fr_burst),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_burst)
  );

  lfl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .burst_i     (q_burst),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[tb/logic_formula_tokenizer_tb.sv]
// Self-checking testbench for logic_formula_tokenizer: streams formula text,
// predicts every token in a scoreboard class and compares the token stream.
// Depends on lfl_pkg and the tokenizer RTL.
`timescale 1ns / 100ps

module logic_formula_tokenizer_tb;
  import lfl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 65;

  class token_scoreboard;
    out_t expected_tokens[$];
    out_t burst[$];
    int mismatches;
    int tokens_seen;
    string kw_words[KW_NUM] = '{"fof", "cnf", "thf", "tff", "include"};

    scan_mode_e mode;
    logic [7:0]  held_byte;
    bit          held_valid;
    logic [31:0] held_off;
    logic [15:0] held_col;
    logic [31:0] tok_start;
    logic [15:0] tok_len;
    logic [15:0] tok_col;
    logic [31:0] offset;
    logic [23:0] line;
    logic [15:0] col;
    logic [4:0]  kw_hits;
    bit          upper_first;
    bit          is_real;

    function new();
      clear();
      mismatches = 0;
      tokens_seen = 0;
    endfunction

    function void clear();
      mode = M_IDLE;
      held_byte = '0;
      held_valid = 0;
      held_off = '0;
      held_col = '0;
      tok_start = '0;
      tok_len = '0;
      tok_col = 16'd1;
      offset = '0;
      line = 24'd1;
      col = 16'd1;
      kw_hits = '1;
      upper_first = 0;
      is_real = 0;
    endfunction

    function bit dig(logic [7:0] c); return c >= "0" && c <= "9"; endfunction
    function bit up(logic [7:0] c); return c >= "A" && c <= "Z"; endfunction
    function bit alp(logic [7:0] c); return up(c) || (c >= "a" && c <= "z"); endfunction
    function bit wrd(logic [7:0] c); return alp(c) || dig(c) || c == "_"; endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v != 16'hFFFF) ? v + 16'd1 : v;
    endfunction

    function void push(logic [5:0] kind, logic [2:0] err, logic [31:0] start,
                       logic [15:0] len, logic [15:0] c);
      out_t t;
      if (burst.size() >= 4) return;
      t = '{token_kind: kind, error_code: err, start_offset: start, token_length: len,
            line_number: line, column_number: c, last_of_run: 1'b0};
      burst.insert(burst.size(), t);
    endfunction

    function void emit_cur(logic [5:0] kind);
      push(kind, E_NONE, tok_start, tok_len, tok_col);
    endfunction

    function void emit_err(logic [2:0] code);
      push(K_ERROR, code, tok_start, tok_len, tok_col);
    endfunction

    function void kw_step(logic [15:0] idx, logic [7:0] c);
      for (int k = 0; k < KW_NUM; k++) begin
        if (idx >= kw_words[k].len() || kw_words[k][idx] != c) kw_hits[k] = 1'b0;
      end
    endfunction

    // Close the token in progress, if any.
    function void flush();
      bit hit;
      hit = 0;
      case (mode)
        M_SLASH, M_SIGN: emit_err(E_UNEXP);
        M_TILDE: emit_cur(K_TILDE);
        M_BANG: emit_cur(K_BANG);
        M_EQ: emit_cur(K_EQ);
        M_LT, M_LT_TILDE: emit_err(E_LT);
        M_LT_EQ: emit_cur(K_LE);
        M_NUM_INT, M_NUM_FRAC, M_NUM_EXP: emit_cur(is_real ? K_REAL : K_INT);
        M_NUM_DOT: begin
          emit_cur(is_real ? K_REAL : K_INT);
          push(K_DOT, E_NONE, held_off, 16'd1, held_col);
        end
        M_NUM_E, M_NUM_ESIGN: emit_err(E_EXPONENT);
        M_IDENT: begin
          for (int k = 0; k < KW_NUM; k++) begin
            if (!hit && kw_hits[k] && tok_len == kw_words[k].len()) begin
              emit_cur(K_KW + 6'(k));
              hit = 1;
            end
          end
          if (!hit) emit_cur(upper_first ? K_VAR : K_NAME);
        end
        M_DOLLAR: emit_cur(K_DOLLAR);
        M_SQ, M_SQ_BS, M_DQ, M_DQ_BS: emit_err(E_UNTERM);
        default: ;
      endcase
      held_valid = 0;
    endfunction

    function void start_tok(logic [7:0] c);
      string singles;
      singles = "()[],.:&|?";
      tok_start = offset;
      tok_col = col;
      tok_len = 16'd1;
      mode = M_IDLE;
      for (int k = 0; k < 10; k++) begin
        if (singles[k] == c) begin
          emit_cur(6'(k));
          return;
        end
      end
      case (c)
        " ", "\t", "\r", "\n": return;
        "%": begin mode = M_COMMENT; return; end
        "/": begin mode = M_SLASH; return; end
        "~": begin mode = M_TILDE; return; end
        "!": begin mode = M_BANG; return; end
        "=": begin mode = M_EQ; return; end
        "<": begin mode = M_LT; return; end
        "+", "-": begin mode = M_SIGN; is_real = 0; return; end
        "'": begin mode = M_SQ; return; end
        "\"": begin mode = M_DQ; return; end
        "$": begin mode = M_DOLLAR; return; end
        default: ;
      endcase
      if (dig(c)) begin
        mode = M_NUM_INT;
        is_real = 0;
      end else if (alp(c) || c == "_") begin
        mode = M_IDENT;
        kw_hits = '1;
        kw_step(16'd0, c);
        upper_first = up(c) || c == "_";
      end else begin
        emit_err(E_UNEXP);
      end
    endfunction

    function void feed(logic [7:0] c);
      bit redo, stop;
      logic [7:0] q;
      scan_mode_e base;
      redo = 1;
      while (redo) begin
        redo = 0;
        stop = 0;
        case (mode)
          M_IDLE: start_tok(c);
          M_COMMENT: if (c == "\n") mode = M_IDLE;
          M_SLASH: if (c == "*") mode = M_BLOCK; else stop = 1;
          M_BLOCK: if (c == "*") mode = M_BLOCK_STAR;
          M_BLOCK_STAR: if (c == "/") mode = M_IDLE; else if (c != "*") mode = M_BLOCK;
          M_TILDE: begin
            if (c == "&" || c == "|") begin
              tok_len = bump(tok_len);
              emit_cur(c == "&" ? K_TILDE_AMP : K_TILDE_BAR);
              mode = M_IDLE;
            end else stop = 1;
          end
          M_BANG: begin
            if (c == "=") begin
              tok_len = bump(tok_len);
              emit_cur(K_NEQ);
              mode = M_IDLE;
            end else stop = 1;
          end
          M_EQ: begin
            if (c == ">") begin
              tok_len = bump(tok_len);
              emit_cur(K_IMPL);
              mode = M_IDLE;
            end else stop = 1;
          end
          M_LT: begin
            if (c == "=" || c == "~") begin
              tok_len = bump(tok_len);
              mode = (c == "=") ? M_LT_EQ : M_LT_TILDE;
            end else stop = 1;
          end
          M_LT_EQ, M_LT_TILDE: begin
            if (c == ">") begin
              tok_len = bump(tok_len);
              emit_cur(mode == M_LT_EQ ? K_EQUIV : K_XOR);
              mode = M_IDLE;
            end else stop = 1;
          end
          M_SIGN: begin
            if (dig(c)) begin
              tok_len = bump(tok_len);
              mode = M_NUM_INT;
            end else stop = 1;
          end
          M_NUM_INT, M_NUM_FRAC: begin
            if (dig(c)) tok_len = bump(tok_len);
            else if (c == "e" || c == "E") begin
              tok_len = bump(tok_len);
              is_real = 1;
              mode = M_NUM_E;
            end else if (c == "." && mode == M_NUM_INT) begin
              // dot is held back until we know whether a fraction follows
              held_byte = c;
              held_valid = 1;
              held_off = offset;
              held_col = col;
              mode = M_NUM_DOT;
            end else stop = 1;
          end
          M_NUM_DOT: begin
            if (dig(c)) begin
              tok_len = bump(bump(tok_len));
              is_real = 1;
              held_valid = 0;
              mode = M_NUM_FRAC;
            end else stop = 1;
          end
          M_NUM_E: begin
            if (c == "+" || c == "-") begin
              tok_len = bump(tok_len);
              mode = M_NUM_ESIGN;
            end else if (dig(c)) begin
              tok_len = bump(tok_len);
              mode = M_NUM_EXP;
            end else stop = 1;
          end
          M_NUM_ESIGN, M_NUM_EXP: begin
            if (dig(c)) begin
              tok_len = bump(tok_len);
              mode = M_NUM_EXP;
            end else stop = 1;
          end
          M_IDENT: begin
            if (wrd(c)) begin
              kw_step(tok_len, c);
              tok_len = bump(tok_len);
            end else stop = 1;
          end
          M_DOLLAR: if (wrd(c)) tok_len = bump(tok_len); else stop = 1;
          M_SQ, M_DQ: begin
            q = (mode == M_SQ) ? "'" : "\"";
            tok_len = bump(tok_len);
            if (c == q) begin
              emit_cur(mode == M_SQ ? K_NAME : K_DISTINCT);
              mode = M_IDLE;
            end else if (c == "\\") begin
              mode = (mode == M_SQ) ? M_SQ_BS : M_DQ_BS;
            end
          end
          M_SQ_BS, M_DQ_BS: begin
            base = (mode == M_SQ_BS) ? M_SQ : M_DQ;
            q = (base == M_SQ) ? "'" : "\"";
            mode = base;
            // only an escaped quote is consumed here; anything else rescans
            if (c == q) tok_len = bump(tok_len);
            else redo = 1;
          end
          default: begin
            mode = M_IDLE;
            redo = 1;
          end
        endcase
        if (stop) begin
          flush();
          mode = M_IDLE;
          redo = 1;
        end
      end
    endfunction

    function void note_input(in_t x);
      burst.delete();
      if (x.command == CMD_END) begin
        flush();
        push(K_END, E_NONE, offset, 16'd0, col);
        clear();
      end else begin
        feed(x.char_byte);
        offset = offset + 32'd1;
        if (x.char_byte == "\n") begin
          col = 16'd1;
          if (line != 24'hFFFFFF) line = line + 24'd1;
        end else if (col != 16'hFFFF) begin
          col = col + 16'd1;
        end
      end
      if (burst.size() > 0) burst[burst.size()-1].last_of_run = 1'b1;
      foreach (burst[i]) expected_tokens.insert(expected_tokens.size(), burst[i]);
    endfunction

    function void report(string what, out_t e, out_t g);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch (%s) at %0t:", what, $time);
        $display("  exp kind=%0d err=%0d off=%0d len=%0d line=%0d col=%0d last=%0d",
                 e.token_kind, e.error_code, e.start_offset, e.token_length,
                 e.line_number, e.column_number, e.last_of_run);
        $display("  got kind=%0d err=%0d off=%0d len=%0d line=%0d col=%0d last=%0d",
                 g.token_kind, g.error_code, g.start_offset, g.token_length,
                 g.line_number, g.column_number, g.last_of_run);
      end
    endfunction

    function void check(out_t got);
      out_t e;
      tokens_seen++;
      if (expected_tokens.size() == 0) begin
        report("no token expected", '0, got);
        return;
      end
      e = expected_tokens.pop_front();
      if (got.token_kind !== e.token_kind || got.error_code !== e.error_code ||
          got.start_offset !== e.start_offset || got.token_length !== e.token_length ||
          got.line_number !== e.line_number || got.column_number !== e.column_number ||
          got.last_of_run !== e.last_of_run)
        report("field", e, got);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  token_scoreboard sb = new();
  int idle_pct;
  int stall_pct;
  int items_sent;
  int cycles;
  byte unsigned frag[$];
  string wc = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

  logic_formula_tokenizer dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiving side: token transfers are checked at the rising edge.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= stall_pct);
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check(out_data_o);
    end
  end

  task automatic send_item(logic cmd, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{command: cmd, char_byte: b};
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(in_data_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(CMD_BYTE, s[i]);
  endtask

  function automatic void add_byte(byte unsigned b);
    frag.insert(frag.size(), b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_digits(int lo, int hi);
    repeat ($urandom_range(hi, lo)) add_byte(8'("0" + $urandom_range(9)));
  endfunction

  function automatic void add_quoted(byte unsigned q);
    add_byte(q);
    repeat ($urandom_range(5)) begin
      if ($urandom_range(99) < 20) begin
        add_byte("\\");
        add_byte($urandom_range(1) ? q : 8'(32 + $urandom_range(94)));
      end else begin
        add_byte(8'(32 + $urandom_range(94)));
        if (frag[$] == q || frag[$] == "\\") frag[$] = "a";
      end
    end
    if ($urandom_range(99) < 90) add_byte(q);
  endfunction

  // One piece of source text; mostly well formed, some broken or noise.
  function automatic void make_fragment();
    string ops[20] = '{"~&", "~|", "~", "!=", "!", "=>", "=", "<=>", "<=", "<~>",
                       "(", ")", "[", "]", ",", ".", ":", "&", "|", "?"};
    string kws[5] = '{"fof", "cnf", "thf", "tff", "include"};
    string bad[8] = '{"<x", "<~a", "/x", "+ ", "1e+;", "3.a", "'\\x'", "-."};
    frag.delete();
    case ($urandom_range(15))
      0, 13: begin
        add_text($urandom_range(2) == 0 ? "_" : "");
        add_byte(wc[$urandom_range(51)]);
        repeat ($urandom_range(6)) add_byte(wc[$urandom_range(wc.len()-1)]);
        add_byte(" ");
      end
      1: begin
        add_text(kws[$urandom_range(4)]);
        if ($urandom_range(1)) add_byte(wc[$urandom_range(wc.len()-1)]);
        add_text("(");
      end
      2: begin
        if ($urandom_range(2) == 0) add_byte($urandom_range(1) ? "+" : "-");
        add_digits(1, 4);
        if ($urandom_range(1)) begin add_text("."); add_digits(1, 3); end
        if ($urandom_range(1)) begin
          add_byte($urandom_range(1) ? "e" : "E");
          if ($urandom_range(1)) add_byte($urandom_range(1) ? "+" : "-");
          add_digits(0, 2);
        end
        if ($urandom_range(1)) add_text(".");
        add_text(",");
      end
      3: add_quoted("'");
      4: add_quoted("\"");
      5, 14: add_text(ops[$urandom_range(19)]);
      6: begin
        repeat ($urandom_range(3, 1)) begin
          case ($urandom_range(3))
            0: add_byte(" ");
            1: add_byte("\t");
            2: add_byte("\r");
            default: add_byte("\n");
          endcase
        end
      end
      7: begin
        add_text("% note ");
        add_byte(8'(32 + $urandom_range(94)));
        add_text("\n");
      end
      8: add_text($urandom_range(1) ? "/* x ** y */" : "/***/");
      9: begin
        add_text($urandom_range(1) ? "$true" : "$");
        repeat ($urandom_range(3)) add_byte(wc[$urandom_range(wc.len()-1)]);
        add_text(" ");
      end
      10: add_text(bad[$urandom_range(7)]);
      11: repeat ($urandom_range(3, 1)) add_byte(8'($urandom_range(255)));
      default: add_text("fof(ax,axiom,![X]:(p(X)<=>~q(X))).\n");
    endcase
  endfunction

  task automatic run_phase(int idle, int stall, int n);
    int start;
    idle_pct = idle;
    stall_pct = stall;
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(99) < 5) send_item(CMD_END, 8'($urandom_range(255)));
      else begin
        make_fragment();
        foreach (frag[i]) send_item(CMD_BYTE, frag[i]);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    items_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: long operators, extreme bytes, odd number endings, open string
    send_text("<~>=>");
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'h00);
    send_text("1.e ");
    send_text("'\\'");
    send_item(CMD_END, 8'hFF);
    send_text("7.");
    send_item(CMD_END, 8'h00);

    run_phase(0, 0, ITEMS_PER_PHASE);
    run_phase(87, 0, ITEMS_PER_PHASE);
    run_phase(0, 87, ITEMS_PER_PHASE);
    run_phase(27, 27, ITEMS_PER_PHASE);
    send_item(CMD_END, 8'h00);
    in_valid_i <= 1'b0;

    while (sb.expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d items over four pacing phases, checked %0d tokens, %0d mismatches",
             items_sent, sb.tokens_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_tokens.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
